FILE: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   // Default sizes
   localparam int DEFAULT_QUEUE_DEPTH   = 16;
   localparam int DEFAULT_PRIORITY_BITS = 16;

   // Fixed field widths on the ports
   localparam int PRIO_FIELD_BITS = 16;
   localparam int OCC_FIELD_BITS  = 5;
   localparam int STATUS_BITS     = 2;
   localparam int RSP_DATA_BITS   = 24;

   // Operation codes carried on req_tuser
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Status codes carried on rsp_tuser
   localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } spq_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
`default_nettype none

module spq_cell #(
   parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS
) (
   input  wire logic                     clock,
   input  wire spq_pkg::spq_cmd_type     cmd,
   input  wire logic [PRIORITY_BITS-1:0] new_value,
   input  wire logic                     in_range,
   input  wire logic [PRIORITY_BITS-1:0] left_value,
   input  wire logic                     left_place,
   input  wire logic [PRIORITY_BITS-1:0] right_value,
   output logic [PRIORITY_BITS-1:0]      value,
   output logic                          place
);

   logic [PRIORITY_BITS-1:0] value_ff;
   logic [PRIORITY_BITS-1:0] value_in;

   // New value belongs here or further in front: empty slot or lower/equal entry
   assign place = !in_range || (value_ff <= new_value);
   assign value = value_ff;

   // Keep, take the new value, shift back on push, or shift forward on pop
   always_comb begin
      value_in = value_ff;
      if (cmd.push) begin
         if (place && !left_place) begin
            value_in = new_value;
         end else if (place) begin
            value_in = left_value;
         end
      end else if (cmd.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue, highest priority leaves first.
// Input channel req_*: one beat is one operation. req_tuser selects push (0)
// or pop (1); req_tdata carries the priority to insert on a push.
// Result channel rsp_*: exactly one beat for every accepted request.
// rsp_tuser is the status (done, pop on empty, push dropped because full),
// rsp_tdata holds the popped priority (zero otherwise) and the occupancy
// after the operation.
// Entries sit in a row of cells, one entry per cell. All cells compare
// against the new value at once and insert/shift together; one operation
// is taken every cycle unless a result stalls, and its result appears in
// the next cycle. Equal priorities: the newest is popped first.
// Reset empties the queue (the count is cleared; cell contents are left).
// When the receiver stalls, the result stays in the output register and
// req_tready drops until that beat is taken; taking it lets a new request
// in on the same edge.
`default_nettype none

module sorted_priority_queue #(
   parameter int QUEUE_DEPTH   = spq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // [15:0] priority_in
   input  wire logic [spq_pkg::PRIO_FIELD_BITS-1:0]       req_tdata,
   // [0] func
   input  wire logic                                      req_tuser,
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // [15:0] priority_out, [20:16] occupancy, [23:21] zero
   output logic [spq_pkg::RSP_DATA_BITS-1:0]              rsp_tdata,
   // [1:0] status
   output logic [spq_pkg::STATUS_BITS-1:0]                rsp_tuser
);

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [spq_pkg::STATUS_BITS-1:0]     rsp_status_ff;
   logic [spq_pkg::STATUS_BITS-1:0]     rsp_status_in;
   logic [spq_pkg::PRIO_FIELD_BITS-1:0] rsp_prio_ff;
   logic [spq_pkg::PRIO_FIELD_BITS-1:0] rsp_prio_in;
   logic [spq_pkg::OCC_FIELD_BITS-1:0]  rsp_occ_ff;
   logic [spq_pkg::OCC_FIELD_BITS-1:0]  rsp_occ_in;

   logic                     accept;
   logic                     is_empty;
   logic                     is_full;
   logic [31:0]              prio_wide;
   logic [31:0]              top_wide;
   logic [PRIORITY_BITS-1:0] new_value;
   spq_pkg::spq_cmd_type     cmd;

   logic [PRIORITY_BITS-1:0] cell_value [QUEUE_DEPTH];
   logic                     cell_place [QUEUE_DEPTH];

   // Handshake: the output register frees up when taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));

   // Reduce the incoming priority to the stored width
   assign prio_wide = 32'(req_tdata);
   assign new_value = prio_wide[PRIORITY_BITS-1:0];
   assign top_wide  = 32'(cell_value[0]);

   assign cmd.push = accept && (req_tuser == spq_pkg::FUNC_PUSH) && !is_full;
   assign cmd.pop  = accept && (req_tuser == spq_pkg::FUNC_POP) && !is_empty;

   // Row of cells, front of the queue at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic in_range;
      assign in_range = (COUNT_BITS'(i) < count_ff);

      spq_cell #(
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .new_value   (new_value),
         .in_range    (in_range),
         .left_value  ((i == 0) ? cell_value[0] : cell_value[(i == 0) ? 0 : i - 1]),
         .left_place  ((i == 0) ? 1'b0 : cell_place[(i == 0) ? 0 : i - 1]),
         .right_value (cell_value[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
         .value       (cell_value[i]),
         .place       (cell_place[i])
      );
   end

   // Count update and result formation
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_prio_in  = '0;
         rsp_occ_in   = spq_pkg::OCC_FIELD_BITS'(count_in);
         if (req_tuser == spq_pkg::FUNC_POP) begin
            if (is_empty) begin
               rsp_status_in = spq_pkg::ST_EMPTY;
            end else begin
               rsp_status_in = spq_pkg::ST_DONE;
               rsp_prio_in   = top_wide[spq_pkg::PRIO_FIELD_BITS-1:0];
            end
         end else if (is_full) begin
            rsp_status_in = spq_pkg::ST_FULL;
         end else begin
            rsp_status_in = spq_pkg::ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_prio_ff};

endmodule

`default_nettype wire

FILE: rtl/spq_checker.sv
`default_nettype none

module spq_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [spq_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input wire logic [spq_pkg::STATUS_BITS-1:0]     rsp_tuser
);

   // Every accepted request yields a result beat on the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no result beat");

   // A stalled result beat holds its contents
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Pop on empty: nothing returned and queue reads empty
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == spq_pkg::ST_EMPTY) |->
         (rsp_tdata[15:0] == 16'd0) && (rsp_tdata[20:16] == 5'd0))
      else $error("empty status with data or occupancy");

   // Dropped push returns no priority
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == spq_pkg::ST_FULL) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("full status with nonzero priority");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
